// ----- hw/rtl/fss_pkg.sv -----
// Shared constants and character helpers for the fuzzy subsequence scorer.
// No dependencies; used by fuzzy_subsequence_scorer, its checker and the testbench.

package fss_pkg;

    localparam int PATTERN_MAX_DEF = 8;

    // Configuration register indexes.
    localparam logic CFG_PATTERN_BYTES  = 1'b0;
    localparam logic CFG_PATTERN_LENGTH = 1'b1;

    localparam logic [5:0] LEN_SAT    = 6'd48;
    localparam logic [7:0] BONUS_BASE = 8'd24;

    // Hit gains.
    localparam logic [6:0] GAIN_FIRST = 7'd8;
    localparam logic [6:0] GAIN_WORD  = 7'd6;
    localparam logic [6:0] GAIN_RUN   = 7'd4;
    localparam logic [6:0] GAIN_PLAIN = 7'd1;

    localparam logic [7:0] SCORE_NO_MATCH = 8'hFF;
    localparam logic [7:0] SCORE_MAX      = 8'd88;

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= 8'h41) && (b <= 8'h5A);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] b);
        return is_upper(b) ? (b + 8'h20) : b;
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) || is_upper(b) ||
               ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

endpackage

// ----- hw/rtl/fuzzy_subsequence_scorer.sv -----
// Fuzzy subsequence scorer: streams candidate bytes against a configured
// pattern and emits one score per candidate. Depends on fss_pkg.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_char_byte, i_char_present, i_last_char
//   output    out        o_out_valid / i_out_stall o_match_score
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One word is taken per cycle unless the input stalls. A word is held in the
// input register, where the match logic updates the candidate state and, on
// the last word, loads the score into the output register.
// A stalled output only holds back a last word; other words keep flowing.
// Reset is synchronous and active low; it clears the pattern, the candidate
// state and both valid flags.

module fuzzy_subsequence_scorer #(
    parameter int PATTERN_MAX = fss_pkg::PATTERN_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_byte,
    input  logic        i_char_present,
    input  logic        i_last_char,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [7:0] o_match_score
);

    logic [PATTERN_MAX-1:0][7:0] r_pattern;
    logic [3:0]                  r_plen;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_present;
    logic       r_last;

    logic [3:0] r_pos,      n_pos;
    logic [6:0] r_total,    n_total;
    logic [5:0] r_len,      n_len;
    logic       r_prev_hit, n_prev_hit;
    logic       r_prev_aln, n_prev_aln;

    logic       r_out_valid;
    logic [7:0] r_score, n_score;

    logic       advance;
    logic       in_take;
    logic [3:0] plen;
    logic [7:0] pat_byte;
    logic       hit;
    logic [6:0] gain;
    logic [7:0] bonus;

    // A last word needs a free output slot; any other word always proceeds.
    assign advance    = r_in_valid && (!r_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign plen = (r_plen > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX) : r_plen;

    always_comb begin
        pat_byte = '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (r_pos == 4'(k)) begin
                pat_byte = r_pattern[k];
            end
        end
    end

    always_comb begin
        hit = r_present && (r_pos < plen) &&
              (fss_pkg::fold(pat_byte) == fss_pkg::fold(r_byte));

        if (r_len == 6'd0) begin
            gain = fss_pkg::GAIN_FIRST;
        end else if (!r_prev_aln) begin
            gain = fss_pkg::GAIN_WORD;
        end else if (r_prev_hit) begin
            gain = fss_pkg::GAIN_RUN;
        end else begin
            gain = fss_pkg::GAIN_PLAIN;
        end

        n_pos      = r_pos;
        n_total    = r_total;
        n_len      = r_len;
        n_prev_hit = r_prev_hit;
        n_prev_aln = r_prev_aln;
        if (r_present) begin
            if (hit) begin
                n_pos   = r_pos + 4'd1;
                n_total = r_total + gain;
            end
            n_prev_hit = hit;
            n_prev_aln = fss_pkg::is_alnum(r_byte);
            if (r_len < fss_pkg::LEN_SAT) begin
                n_len = r_len + 6'd1;
            end
        end

        // Length saturates at 48, so half of it never exceeds the base.
        bonus = fss_pkg::BONUS_BASE - {3'b000, n_len[5:1]};

        if (plen == 4'd0) begin
            n_score = 8'd0;
        end else if (n_pos < plen) begin
            n_score = fss_pkg::SCORE_NO_MATCH;
        end else begin
            n_score = {1'b0, n_total} + bonus;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern   <= '0;
            r_plen      <= '0;
            r_in_valid  <= 1'b0;
            r_pos       <= '0;
            r_total     <= '0;
            r_len       <= '0;
            r_prev_hit  <= 1'b0;
            r_prev_aln  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fss_pkg::CFG_PATTERN_BYTES:  r_pattern <= i_cfg_data[PATTERN_MAX*8-1:0];
                    fss_pkg::CFG_PATTERN_LENGTH: r_plen    <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                if (r_last) begin
                    r_pos      <= '0;
                    r_total    <= '0;
                    r_len      <= '0;
                    r_prev_hit <= 1'b0;
                    r_prev_aln <= 1'b0;
                end else begin
                    r_pos      <= n_pos;
                    r_total    <= n_total;
                    r_len      <= n_len;
                    r_prev_hit <= n_prev_hit;
                    r_prev_aln <= n_prev_aln;
                end
            end

            if (advance && r_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte    <= i_char_byte;
            r_present <= i_char_present;
            r_last    <= i_last_char;
        end
        if (advance && r_last) begin
            r_score <= n_score;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_score = r_score;

endmodule

// ----- hw/rtl/fss_checker.sv -----
// Port-level checks for fuzzy_subsequence_scorer, attached by a bind.
// Depends on fss_pkg.

module fss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_match_score
);

    // Reset leaves both sides empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not empty after reset");

    // The input side only backs up behind a blocked result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output free");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_match_score)))
        else $error("stalled result changed");

    // Scores are either the no-match code or within the reachable range.
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_match_score == fss_pkg::SCORE_NO_MATCH) ||
                         (o_match_score <= fss_pkg::SCORE_MAX)))
        else $error("score out of range");

endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_match_score (o_match_score)
);

// ----- tb/fuzzy_subsequence_scorer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for fuzzy_subsequence_scorer: random candidate strings,
// predicted scores, and randomized stalls on both channels. Depends on fss_pkg.

module fuzzy_subsequence_scorer_tb;

    // Tracks the candidate being scored and queues the score that each last word earns.
    class match_score_book;
        logic [63:0] pat_bytes;
        logic [3:0]  pat_len;
        logic [3:0]  matched;
        logic [6:0]  gain_sum;
        logic [5:0]  seen_len;
        logic        last_hit;
        logic        last_alnum;
        logic [7:0]  expected_scores[$];
        int          mismatches;

        function new();
            pat_bytes  = '0;
            pat_len    = '0;
            mismatches = 0;
            clear_candidate();
        endfunction

        function void clear_candidate();
            matched    = '0;
            gain_sum   = '0;
            seen_len   = '0;
            last_hit   = 1'b0;
            last_alnum = 1'b0;
        endfunction

        function logic [7:0] fold_case(logic [7:0] b);
            return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
        endfunction

        function logic is_word_byte(logic [7:0] b);
            return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                   (b >= 8'h61 && b <= 8'h7A);
        endfunction

        function void set_register(logic idx, logic [63:0] data);
            if (idx == fss_pkg::CFG_PATTERN_BYTES) begin
                pat_bytes = data;
            end else begin
                pat_len = data[3:0];
            end
        endfunction

        function int used_len();
            return (pat_len > 4'd8) ? 8 : int'(pat_len);
        endfunction

        function void note_word(logic [7:0] b, logic present, logic last);
            int         n;
            int         half;
            logic [7:0] pb;
            logic [6:0] gain;
            logic       hit;
            logic [7:0] score;
            n = used_len();
            if (present) begin
                hit = 1'b0;
                if (int'(matched) < n) begin
                    pb = pat_bytes[int'(matched) * 8 +: 8];
                    if (fold_case(pb) == fold_case(b)) begin
                        // First byte beats a word start, which beats a run, which beats the rest.
                        if (seen_len == 0) gain = 7'd8;
                        else if (!last_alnum) gain = 7'd6;
                        else if (last_hit) gain = 7'd4;
                        else gain = 7'd1;
                        gain_sum = gain_sum + gain;
                        matched  = matched + 4'd1;
                        hit      = 1'b1;
                    end
                end
                last_hit   = hit;
                last_alnum = is_word_byte(b);
                if (seen_len < 6'd48) seen_len = seen_len + 6'd1;
            end
            if (!last) return;
            if (n == 0) begin
                score = 8'd0;
            end else if (int'(matched) < n) begin
                score = fss_pkg::SCORE_NO_MATCH;
            end else begin
                half  = int'(seen_len) / 2;
                score = 8'(int'(gain_sum) + ((half < 24) ? (24 - half) : 0));
            end
            expected_scores.push_back(score);
            clear_candidate();
        endfunction

        task report(string what);
            $display("[%0t] score mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_score(logic [7:0] got);
            logic [7:0] want;
            if (expected_scores.size() == 0) begin
                report($sformatf("score %0d with none expected", $signed(got)));
                return;
            end
            want = expected_scores.pop_front();
            if (got !== want) begin
                report($sformatf("got %0d, expected %0d", $signed(got), $signed(want)));
            end
        endtask

        function int pending();
            return expected_scores.size();
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_index    = 1'b0;
    logic [63:0] i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_char_byte    = '0;
    logic        i_char_present = 1'b0;
    logic        i_last_char    = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic signed [7:0] o_match_score;

    match_score_book book;
    int counted;
    bit no_idle;
    bit hold_req;
    int hold_left;

    fuzzy_subsequence_scorer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_byte    (i_char_byte),
        .i_char_present (i_char_present),
        .i_last_char    (i_last_char),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_match_score  (o_match_score)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Score receiver: checks accepted scores and stalls at random or on a hold request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) book.check_score(o_match_score);
            if (hold_req) begin
                hold_left = 60;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= !no_idle && ($urandom_range(0, 99) < 24);
            end
        end
    end

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'h61 + 8'($urandom_range(0, 25));
            3, 4:    return 8'h41 + 8'($urandom_range(0, 25));
            5:       return 8'h30 + 8'($urandom_range(0, 9));
            6, 7:    return 8'($urandom_range(0, 127));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] b);
        logic [7:0] low;
        low = b | 8'h20;
        if (low >= 8'h61 && low <= 8'h7A && $urandom_range(0, 1) == 1) return b ^ 8'h20;
        return b;
    endfunction

    task automatic send_word(input logic [7:0] b, input logic present, input logic last);
        while (!no_idle && $urandom_range(0, 99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_char_byte    <= b;
        i_char_present <= present;
        i_last_char    <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        book.note_word(b, present, last);
        counted++;
    endtask

    // Let every score out, then keep the input idle for a word still in the pipeline.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [63:0] pattern, input logic [63:0] len_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= fss_pkg::CFG_PATTERN_BYTES;
        i_cfg_data  <= pattern;
        book.set_register(fss_pkg::CFG_PATTERN_BYTES, pattern);
        @(posedge i_clk);
        i_cfg_index <= fss_pkg::CFG_PATTERN_LENGTH;
        i_cfg_data  <= len_data;
        book.set_register(fss_pkg::CFG_PATTERN_LENGTH, len_data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mode 0: pattern embedded in filler, 1: one pattern byte dropped, 2: noise.
    task automatic send_candidate(input int mode);
        logic [7:0] word_q[$];
        int         n;
        int         skip;
        int         fill;
        bit         longer;
        bit         sep_last;
        n      = book.used_len();
        longer = ($urandom_range(0, 99) < 8);
        if (mode == 2) begin
            fill = longer ? $urandom_range(40, 60) : $urandom_range(0, 12);
            repeat (fill) word_q.push_back(random_byte());
        end else begin
            skip = (mode == 1 && n > 0) ? $urandom_range(0, n - 1) : -1;
            for (int k = 0; k < n; k++) begin
                fill = longer ? $urandom_range(0, 8) :
                       ($urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 2));
                repeat (fill) word_q.push_back(random_byte());
                if (k != skip) word_q.push_back(flip_case(book.pat_bytes[k * 8 +: 8]));
            end
            fill = longer ? $urandom_range(20, 40) : $urandom_range(0, 2);
            repeat (fill) word_q.push_back(random_byte());
        end
        sep_last = (word_q.size() == 0) || ($urandom_range(0, 99) < 20);
        foreach (word_q[i]) begin
            if ($urandom_range(0, 99) < 8) send_word(random_byte(), 1'b0, 1'b0);
            send_word(word_q[i], 1'b1, (i == word_q.size() - 1) && !sep_last);
        end
        if (sep_last) send_word(random_byte(), 1'b0, 1'b1);
    endtask

    initial begin
        int          phase;
        int          len;
        int          pick;
        logic [63:0] pattern;
        logic [63:0] len_data;
        book    = new();
        counted = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset leaves an empty pattern: any candidate, even an empty one, scores zero.
        send_word("x", 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        drain();

        configure(64'h4261, 64'd2);
        send_word("A", 1'b1, 1'b0);
        send_word("b", 1'b1, 1'b1);
        send_word("-", 1'b1, 1'b0);
        send_word("a", 1'b1, 1'b0);
        send_word("x", 1'b1, 1'b0);
        send_word("B", 1'b1, 1'b1);
        send_word("z", 1'b1, 1'b0);
        send_word("b", 1'b0, 1'b0);
        send_word("a", 1'b1, 1'b0);
        send_word("?", 1'b1, 1'b0);
        send_word("b", 1'b1, 1'b1);
        send_word("q", 1'b1, 1'b1);
        send_word(8'hFF, 1'b0, 1'b1);
        drain();

        // An oversized length acts as eight; high bytes compare without case folding.
        configure(64'hFFFF_FFFF_FFFF_FFFF, 64'd15);
        send_word(8'hDF, 1'b1, 1'b1);
        repeat (8) send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b1);
        drain();

        phase = 0;
        while (counted < 1150) begin
            case (phase)
                0: len = 8;
                1: len = 15;
                2: len = 0;
                3: len = 1;
                default: begin
                    pick = $urandom_range(0, 9);
                    len  = (pick == 0) ? 0 :
                           (pick == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
                end
            endcase
            if (phase == 2) begin
                pattern = '0;
            end else begin
                for (int k = 0; k < 8; k++) pattern[k * 8 +: 8] = random_byte();
            end
            len_data = 64'(len);
            if ($urandom_range(0, 3) == 0) len_data[63:4] = 60'({$urandom, $urandom});
            configure(pattern, len_data);
            // The receiver holds off once while words keep coming, so the block backs up.
            if (phase == 4) hold_req = 1'b1;
            no_idle = (phase >= 6 && phase < 10);
            repeat ($urandom_range(4, 10)) begin
                pick = $urandom_range(0, 99);
                send_candidate(pick < 70 ? 0 : (pick < 85 ? 1 : 2));
            end
            drain();
            phase++;
        end

        repeat (6) @(posedge i_clk);
        if (book.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
